@@ rtl/core/cds_pkg.sv @@
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types and codes for the calendar date stepper: command codes,
// compare result codes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package cds_pkg;

	// command codes carried in the op field
	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_ADVANCE = 2'd1;
	localparam logic [1:0] OP_COMPARE = 2'd2;

	// compare result codes
	localparam logic [1:0] ORD_EARLIER = 2'd0;
	localparam logic [1:0] ORD_EQUAL   = 2'd1;
	localparam logic [1:0] ORD_LATER   = 2'd2;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_RESP
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;     // overwrite the stored date with the request date
		logic start;    // load the day counter and direction from the offset
		logic capture;  // write the order register
		logic compare;  // order register takes the compare result, else earlier
		logic step;     // move the stored date by one day, count down
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic cnt_zero; // no days left to step
	} status_t;

endpackage

@@ rtl/core/cds_ctrl.sv @@
// ----------------------------------------------------------------------------
// cds_ctrl
// Controller of the calendar date stepper: takes a request, sequences the
// day steps of an advance and holds the result until it is taken.
// ----------------------------------------------------------------------------
module cds_ctrl
	import cds_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	output logic       out_valid,
	input  logic       out_ready,
	output cmd_t       cmd,
	input  status_t    status
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (op)
						OP_LOAD: begin
							cmd.load = 1'b1;
							state_d  = ST_RESP;
						end
						OP_ADVANCE: begin
							cmd.start = 1'b1;
							state_d   = ST_STEP;
						end
						OP_COMPARE: begin
							cmd.compare = 1'b1;
							state_d     = ST_RESP;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_STEP: begin
				// advance one day per cycle until the counter runs out
				if (status.cnt_zero) begin
					state_d = ST_RESP;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_RESP: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/cds_dp.sv @@
// ----------------------------------------------------------------------------
// cds_dp
// Datapath of the calendar date stepper: the stored date, the day counter,
// the one-day step logic with the leap-year test, and the date compare.
// ----------------------------------------------------------------------------
module cds_dp
	import cds_pkg::*;
#(
	parameter int OFFSET_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output status_t                       status,
	input  logic signed [15:0]            in_year,
	input  logic [3:0]                    in_month,
	input  logic [4:0]                    in_day,
	input  logic signed [OFFSET_BITS-1:0] day_offset,
	output logic signed [15:0]            out_year,
	output logic [3:0]                    out_month,
	output logic [4:0]                    out_day,
	output logic [1:0]                    order
);

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [4:0] RES_NEG   = 5'd11; // 65536 mod 25
	localparam logic [OFFSET_BITS-1:0] CNT_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

	// residue of a 16-bit unsigned value modulo 25, by folding nibbles
	function automatic logic [4:0] mod25(input logic [15:0] u);
		logic [9:0] s1;
		logic [7:0] s2;
		logic [6:0] s3;
		logic [6:0] r;
		s1 = 10'(u[3:0]) + 10'({u[7:4], 4'd0}) + 10'(u[11:8]) * 10'd6
			+ 10'(u[15:12]) * 10'd21;
		s2 = 8'(s1[4:0]) + 8'(s1[9:5]) * 8'd7;
		s3 = 7'(s2[4:0]) + 7'(s2[7:5]) * 7'd7;
		if (s3 >= 7'd75) begin
			r = s3 - 7'd75;
		end else if (s3 >= 7'd50) begin
			r = s3 - 7'd50;
		end else if (s3 >= 7'd25) begin
			r = s3 - 7'd25;
		end else begin
			r = s3;
		end
		return r[4:0];
	endfunction

	// leap year on the signed year: by 4 and not 100, or by 400
	function automatic logic is_leap(input logic signed [15:0] y);
		logic div4;
		logic div16;
		logic div25;
		div4  = (y[1:0] == 2'd0);
		div16 = (y[3:0] == 4'd0);
		div25 = (mod25(y) == (y[15] ? RES_NEG : 5'd0));
		return (div4 && !div25) || (div16 && div25);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		if (m == MONTH_FEB) begin
			len = leap ? 5'd29 : 5'd28;
		end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP
				|| m == MONTH_NOV) begin
			len = 5'd30;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

	logic signed [15:0]     year_q;
	logic [3:0]             month_q;
	logic [4:0]             day_q;
	logic [1:0]             order_q;
	logic [OFFSET_BITS-1:0] cnt_q;
	logic                   fwd_q;

	logic signed [15:0]     year_d;
	logic [3:0]             month_d;
	logic [4:0]             day_d;
	logic                   leap;
	logic [4:0]             cur_len;
	logic [3:0]             prev_month;
	logic [1:0]             cmp_res;
	logic                   off_pos;
	logic [OFFSET_BITS-1:0] off_mag;

	assign leap       = is_leap(year_q);
	assign cur_len    = month_len(month_q, leap);
	assign prev_month = (month_q == MONTH_JAN) ? MONTH_DEC : month_q - 4'd1;

	// one-day step in the current direction
	always_comb begin
		year_d  = year_q;
		month_d = month_q;
		day_d   = day_q;
		if (month_q >= MONTH_JAN && month_q <= MONTH_DEC) begin
			if (fwd_q) begin
				if (day_q == cur_len) begin
					day_d = 5'd1;
					if (month_q == MONTH_DEC) begin
						month_d = MONTH_JAN;
						year_d  = year_q + 16'sd1;
					end else begin
						month_d = month_q + 4'd1;
					end
				end else begin
					day_d = day_q + 5'd1;
				end
			end else begin
				if (day_q == 5'd1) begin
					month_d = prev_month;
					if (month_q == MONTH_JAN) begin
						year_d = year_q - 16'sd1;
					end
					// February is only reached from March, same year
					day_d = month_len(prev_month, leap);
				end else begin
					day_d = day_q - 5'd1;
				end
			end
		end
	end

	// compare stored date with the request date
	always_comb begin
		if (year_q < in_year) begin
			cmp_res = ORD_EARLIER;
		end else if (year_q > in_year) begin
			cmp_res = ORD_LATER;
		end else if (month_q < in_month) begin
			cmp_res = ORD_EARLIER;
		end else if (month_q > in_month) begin
			cmp_res = ORD_LATER;
		end else if (day_q < in_day) begin
			cmp_res = ORD_EARLIER;
		end else if (day_q > in_day) begin
			cmp_res = ORD_LATER;
		end else begin
			cmp_res = ORD_EQUAL;
		end
	end

	// direction and magnitude of the offset
	assign off_pos = !day_offset[OFFSET_BITS-1] && (day_offset != '0);
	assign off_mag = day_offset[OFFSET_BITS-1] ? ('0 - day_offset) : day_offset;

	// stored date
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q  <= '0;
			month_q <= 4'd1;
			day_q   <= 5'd1;
		end else if (cmd.load) begin
			year_q  <= in_year;
			month_q <= in_month;
			day_q   <= in_day;
		end else if (cmd.step) begin
			year_q  <= year_d;
			month_q <= month_d;
			day_q   <= day_d;
		end
	end

	// day counter and direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fwd_q <= 1'b0;
		end else if (cmd.start) begin
			cnt_q <= off_mag;
			fwd_q <= off_pos;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - CNT_ONE;
		end
	end

	// hold the order of the current request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			order_q <= cmd.compare ? cmp_res : ORD_EARLIER;
		end
	end

	assign status.cnt_zero = (cnt_q == '0);
	assign out_year        = year_q;
	assign out_month       = month_q;
	assign out_day         = day_q;
	assign order           = order_q;

endmodule

@@ rtl/core/calendar_date_stepper.sv @@
// ----------------------------------------------------------------------------
// calendar_date_stepper
// Gregorian date register with load, advance by a signed day count, and
// compare; one result per request.
// ----------------------------------------------------------------------------
// A request is taken when in_valid and in_ready are high; one result follows,
// carrying the stored date and, for a compare, the order of the stored date
// against the request date. Load, compare and an unused op do their work on
// acceptance and present their result the cycle after acceptance. An advance
// moves the date one day per cycle through the single step unit and checks
// the day counter once more after the last step before presenting its result.
// The result is held until out_ready; the next request is taken in the cycle
// after the result leaves.
module calendar_date_stepper
	import cds_pkg::*;
#(
	parameter int OFFSET_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    op,
	input  logic signed [15:0]            in_year,
	input  logic [3:0]                    in_month,
	input  logic [4:0]                    in_day,
	input  logic signed [OFFSET_BITS-1:0] day_offset,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [15:0]            out_year,
	output logic [3:0]                    out_month,
	output logic [4:0]                    out_day,
	output logic [1:0]                    order
);

	cmd_t    cmd;
	status_t status;

	// sequence requests
	cds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// hold and step the date
	cds_dp #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_year    (in_year),
		.in_month   (in_month),
		.in_day     (in_day),
		.day_offset (day_offset),
		.out_year   (out_year),
		.out_month  (out_month),
		.out_day    (out_day),
		.order      (order)
	);

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the calendar date stepper. A directed table covers
// load/advance/compare, year wrap both ways, leap years on either side of
// zero, out-of-range months and unvalidated days. Random requests follow,
// checked against a day-by-day calendar predictor under varied handshake
// idling on both channels.
// ----------------------------------------------------------------------------
module tb
	import cds_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// op code 3 has no meaning; the date must stay put
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RAND_PER_PHASE = 18;

	typedef struct packed {
		logic [1:0]        op;
		logic signed [15:0] year;
		logic [3:0]        month;
		logic [4:0]        day;
		logic signed [15:0] offset;
	} date_req_t;

	typedef struct packed {
		logic signed [15:0] year;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [1:0]        ord;
	} date_res_t;

	typedef struct packed {
		date_req_t req;
		bit        typed;
		date_res_t res;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         op;
	logic signed [15:0] in_year;
	logic [3:0]         in_month;
	logic [4:0]         in_day;
	logic signed [15:0] day_offset;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] out_year;
	logic [3:0]         out_month;
	logic [4:0]         out_day;
	logic [1:0]         order;

	// predicted calendar state
	logic signed [15:0] cal_year;
	logic [3:0]         cal_month;
	logic [4:0]         cal_day;

	date_res_t date_exp_q[$];
	dir_row_t  dir_tab[$];
	int        err_count;
	int        send_idle_pct;
	int        recv_stall_pct;

	calendar_date_stepper #(
		.OFFSET_BITS(16)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.in_year   (in_year),
		.in_month  (in_month),
		.in_day    (in_day),
		.day_offset(day_offset),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_year  (out_year),
		.out_month (out_month),
		.out_day   (out_day),
		.order     (order)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// abort a hung run
	initial begin
		#100ms;
		$display("Regression FAIL");
		$finish;
	end

	// days in a month, leap rule tested on the signed year
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic signed [15:0] y);
		int v;
		v = $signed(y);
		if (m == 4'd2)
			return (((v % 4 == 0) && (v % 100 != 0)) || (v % 400 == 0)) ? 5'd29 : 5'd28;
		if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11)
			return 5'd30;
		return 5'd31;
	endfunction

	// apply one request to the predicted calendar and form its result
	task automatic advance_calendar(input date_req_t rq, output date_res_t r);
		int off;
		int n;
		r.ord = ORD_EARLIER;
		case (rq.op)
			OP_LOAD: begin
				cal_year  = rq.year;
				cal_month = rq.month;
				cal_day   = rq.day;
			end
			OP_ADVANCE: begin
				off = $signed(rq.offset);
				n = (off < 0) ? -off : off;
				repeat (n) begin
					// hold the date while the month is out of range
					if (cal_month >= 4'd1 && cal_month <= 4'd12) begin
						if (off > 0) begin
							if (cal_day == month_days(cal_month, cal_year)) begin
								cal_day = 5'd1;
								if (cal_month == 4'd12) begin
									cal_month = 4'd1;
									cal_year  = cal_year + 16'sd1;
								end else begin
									cal_month = cal_month + 4'd1;
								end
							end else begin
								cal_day = cal_day + 5'd1;
							end
						end else begin
							if (cal_day == 5'd1) begin
								if (cal_month == 4'd1) begin
									cal_month = 4'd12;
									cal_year  = cal_year - 16'sd1;
								end else begin
									cal_month = cal_month - 4'd1;
								end
								cal_day = month_days(cal_month, cal_year);
							end else begin
								cal_day = cal_day - 5'd1;
							end
						end
					end
				end
			end
			OP_COMPARE: begin
				if ($signed(cal_year) < $signed(rq.year))
					r.ord = ORD_EARLIER;
				else if ($signed(cal_year) > $signed(rq.year))
					r.ord = ORD_LATER;
				else if (cal_month < rq.month)
					r.ord = ORD_EARLIER;
				else if (cal_month > rq.month)
					r.ord = ORD_LATER;
				else if (cal_day < rq.day)
					r.ord = ORD_EARLIER;
				else if (cal_day > rq.day)
					r.ord = ORD_LATER;
				else
					r.ord = ORD_EQUAL;
			end
			default: ;
		endcase
		r.year  = cal_year;
		r.month = cal_month;
		r.day   = cal_day;
	endtask

	// present one request, wait for acceptance, queue its expected result
	task automatic send_request(input date_req_t rq, input bit typed, input date_res_t typed_res);
		date_res_t pred;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		op         <= rq.op;
		in_year    <= rq.year;
		in_month   <= rq.month;
		in_day     <= rq.day;
		day_offset <= rq.offset;
		do @(posedge clk); while (!in_ready);
		advance_calendar(rq, pred);
		date_exp_q.push_back(typed ? typed_res : pred);
	endtask

	// table rows: predicted, or with the expected result typed in
	task automatic row(input logic [1:0] o, input int y, input int m, input int d, input int off);
		dir_row_t t;
		t.req   = '{o, 16'(y), 4'(m), 5'(d), 16'(off)};
		t.typed = 1'b0;
		t.res   = '0;
		dir_tab.push_back(t);
	endtask

	task automatic row_chk(input logic [1:0] o, input int y, input int m, input int d,
			input int off, input int ey, input int em, input int ed, input logic [1:0] eo);
		dir_row_t t;
		t.req   = '{o, 16'(y), 4'(m), 5'(d), 16'(off)};
		t.typed = 1'b1;
		t.res   = '{16'(ey), 4'(em), 5'(ed), eo};
		dir_tab.push_back(t);
	endtask

	// stall the result channel at the current rate
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// check every accepted result against the oldest expectation
	always @(posedge clk) begin : result_check
		date_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (date_exp_q.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected result %0d-%0d-%0d order %0d",
						out_year, out_month, out_day, order);
			end else begin
				want = date_exp_q.pop_front();
				if (out_year !== want.year || out_month !== want.month ||
						out_day !== want.day || order !== want.ord) begin
					err_count++;
					if (err_count <= 10)
						$display({"mismatch: expected %0d-%0d-%0d order %0d, ",
							"got %0d-%0d-%0d order %0d"},
							want.year, want.month, want.day, want.ord,
							out_year, out_month, out_day, order);
				end
			end
		end
	end

	initial begin : stimulus
		date_req_t rq;
		int        pick;
		int        sel;
		err_count      = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		cal_year       = 16'sd0;
		cal_month      = 4'd1;
		cal_day        = 5'd1;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		op             = OP_LOAD;
		in_year        = '0;
		in_month       = '0;
		in_day         = '0;
		day_offset     = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reset value, year wrap both ways
		row_chk(OP_COMPARE, 0, 1, 1, 0, 0, 1, 1, ORD_EQUAL);
		row_chk(OP_LOAD, 32767, 12, 31, 0, 32767, 12, 31, ORD_EARLIER);
		row_chk(OP_ADVANCE, 0, 0, 0, 1, -32768, 1, 1, ORD_EARLIER);
		row_chk(OP_ADVANCE, 0, 0, 0, -1, 32767, 12, 31, ORD_EARLIER);
		// month out of range holds the date; unused op holds it too
		row_chk(OP_LOAD, -32768, 15, 31, 0, -32768, 15, 31, ORD_EARLIER);
		row_chk(OP_ADVANCE, 0, 0, 0, 7, -32768, 15, 31, ORD_EARLIER);
		row_chk(OP_UNUSED, 21845, 10, 21, -21846, -32768, 15, 31, ORD_EARLIER);
		// leap years: century rule, zero and negative years
		row_chk(OP_LOAD, 2000, 2, 28, 0, 2000, 2, 28, ORD_EARLIER);
		row(OP_ADVANCE, 0, 0, 0, 1);
		row(OP_ADVANCE, 0, 0, 0, 1);
		row_chk(OP_LOAD, 0, 2, 28, 0, 0, 2, 28, ORD_EARLIER);
		row(OP_ADVANCE, 0, 0, 0, 1);
		row_chk(OP_LOAD, -4, 2, 28, 0, -4, 2, 28, ORD_EARLIER);
		row(OP_ADVANCE, 0, 0, 0, 1);
		row_chk(OP_LOAD, -100, 2, 28, 0, -100, 2, 28, ORD_EARLIER);
		row(OP_ADVANCE, 0, 0, 0, 1);
		// unvalidated day wraps modulo 32
		row_chk(OP_LOAD, 2023, 4, 31, 0, 2023, 4, 31, ORD_EARLIER);
		row(OP_ADVANCE, 0, 0, 0, 1);
		row(OP_ADVANCE, 0, 0, 0, -1);
		// zero offset and the earlier and later compare outcomes
		row_chk(OP_LOAD, 2024, 6, 15, 0, 2024, 6, 15, ORD_EARLIER);
		row_chk(OP_ADVANCE, 0, 0, 0, 0, 2024, 6, 15, ORD_EARLIER);
		row_chk(OP_COMPARE, 2024, 6, 16, 0, 2024, 6, 15, ORD_EARLIER);
		row_chk(OP_COMPARE, 2023, 12, 31, 0, 2024, 6, 15, ORD_LATER);
		row_chk(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, ORD_EARLIER);
		// offset extremes
		row_chk(OP_LOAD, 1, 1, 1, 0, 1, 1, 1, ORD_EARLIER);
		row(OP_ADVANCE, 0, 0, 0, 32767);
		row(OP_ADVANCE, 0, 0, 0, -32768);

		foreach (dir_tab[i])
			send_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);

		// random requests over four idling phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			// hold off the sender until the block has drained
			if (ph == 2) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (date_exp_q.size() != 0) @(posedge clk);
			end
			for (int k = 0; k < RAND_PER_PHASE; k++) begin
				pick      = $urandom_range(99);
				sel       = $urandom_range(9);
				rq.year   = 16'($urandom);
				rq.month  = 4'($urandom);
				rq.day    = 5'($urandom);
				rq.offset = 16'($urandom);
				if (pick < 45) begin
					// advance: mostly short moves, a few long
					rq.op = OP_ADVANCE;
					if (sel < 6)
						rq.offset = 16'(int'($urandom_range(80)) - 40);
					else if (sel < 9)
						rq.offset = 16'(int'($urandom_range(800)) - 400);
					else
						rq.offset = 16'(int'($urandom_range(6000)) - 3000);
				end else if (pick < 70) begin
					// load: mostly well-formed dates, some near the wrap, some raw
					rq.op = OP_LOAD;
					if (sel < 7) begin
						rq.year  = 16'(int'($urandom_range(2800)) - 400);
						rq.month = 4'($urandom_range(12, 1));
						rq.day   = 5'($urandom_range(month_days(rq.month, rq.year), 1));
					end else if (sel < 9) begin
						if ($urandom_range(1)) begin
							rq.year  = 16'sh7fff;
							rq.month = 4'd12;
							rq.day   = 5'($urandom_range(31, 20));
						end else begin
							rq.year  = 16'sh8000;
							rq.month = 4'd1;
							rq.day   = 5'($urandom_range(10, 1));
						end
					end
				end else if (pick < 95) begin
					// compare: near the stored date to hit all outcomes
					rq.op = OP_COMPARE;
					if (sel < 8) begin
						rq.year  = cal_year;
						rq.month = cal_month;
						rq.day   = cal_day;
						case (sel)
							1: rq.year  = cal_year + 16'sd1;
							2: rq.year  = cal_year - 16'sd1;
							3: rq.month = 4'($urandom);
							4: rq.month = cal_month + 4'd1;
							5: rq.day   = 5'($urandom);
							6: rq.day   = cal_day - 5'd1;
							default: ;
						endcase
					end
				end else begin
					rq.op = OP_UNUSED;
				end
				send_request(rq, 1'b0, '0);
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then allow a short tail for stray results
		while (date_exp_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (err_count == 0 && date_exp_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
